// ===== sv/oabs_pkg.sv =====
// Package: shared constants, configuration and control types for overlap-add synthesis.
`timescale 1ns / 1ps
package oabs_pkg;

  localparam int MAX_OVERLAP   = 128;
  localparam int SAMPLE_BITS   = 24;
  localparam int POSITION_BITS = 16;
  localparam int IDX_BITS      = $clog2(MAX_OVERLAP);
  localparam int WIN_BITS      = 16;
  localparam int SIZE_BITS     = 9;
  localparam int OVL_BITS      = 8;
  localparam int COUNT_BITS    = 9;
  localparam int NORM_BITS     = 24;
  localparam int PIXEL_BITS    = 8;
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 32;

  localparam logic [WIN_BITS-1:0] ONE_Q15 = 16'h8000;
  localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = 8'd255;

  // Register indexes
  localparam logic [2:0] REG_BLOCK_WIDTH    = 3'd0;
  localparam logic [2:0] REG_BLOCK_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_OVERLAP_WIDTH  = 3'd2;
  localparam logic [2:0] REG_OVERLAP_HEIGHT = 3'd3;
  localparam logic [2:0] REG_BLOCKS_ACROSS  = 3'd4;
  localparam logic [2:0] REG_BLOCKS_DOWN    = 3'd5;
  localparam logic [2:0] REG_NORM_SCALE     = 3'd6;
  localparam logic [2:0] REG_PLANE_BASE     = 3'd7;

  // Window table selects
  localparam logic [1:0] TBL_X_LEFT  = 2'd0;
  localparam logic [1:0] TBL_X_RIGHT = 2'd1;
  localparam logic [1:0] TBL_Y_LEFT  = 2'd2;
  localparam logic [1:0] TBL_Y_RIGHT = 2'd3;

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef struct packed {
    logic [SIZE_BITS-1:0]  block_width;
    logic [SIZE_BITS-1:0]  block_height;
    logic [OVL_BITS-1:0]   overlap_width;
    logic [OVL_BITS-1:0]   overlap_height;
    logic [COUNT_BITS-1:0] blocks_across;
    logic [COUNT_BITS-1:0] blocks_down;
    logic [NORM_BITS-1:0]  norm_scale;
    logic [PIXEL_BITS-1:0] plane_base;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic capture;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

// ===== sv/oabs_if.sv =====
// Stream interfaces: input item channel and result channel.
`timescale 1ns / 1ps
interface oabs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  func;
  logic [1:0]                            table_select;
  logic [6:0]                            table_index;
  logic [15:0]                           table_value;
  logic signed [oabs_pkg::SAMPLE_BITS-1:0] sample_own;
  logic signed [oabs_pkg::SAMPLE_BITS-1:0] sample_right;
  logic signed [oabs_pkg::SAMPLE_BITS-1:0] sample_below;
  logic signed [oabs_pkg::SAMPLE_BITS-1:0] sample_diag;

  modport source (output valid, func, table_select, table_index, table_value,
                  sample_own, sample_right, sample_below, sample_diag, input ready);
  modport sink (input valid, func, table_select, table_index, table_value,
                sample_own, sample_right, sample_below, sample_diag, output ready);
endinterface

interface oabs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       line_end;
  logic       frame_end;

  modport source (output valid, pixel, line_end, frame_end, input ready);
  modport sink (input valid, pixel, line_end, frame_end, output ready);
endinterface

// ===== sv/oabs_cfg.sv =====
// Configuration register file with APB-style access.
`timescale 1ns / 1ps
module oabs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [oabs_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [oabs_pkg::DATA_BITS-1:0] cfg_pwdata,
  output logic [oabs_pkg::DATA_BITS-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output oabs_pkg::cfg_t                 cfg
);
  import oabs_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_width    <= 9'd32;
      cfg_r.block_height   <= 9'd32;
      cfg_r.overlap_width  <= 8'd16;
      cfg_r.overlap_height <= 8'd16;
      cfg_r.blocks_across  <= 9'd1;
      cfg_r.blocks_down    <= 9'd1;
      cfg_r.norm_scale     <= 24'd16384;
      cfg_r.plane_base     <= 8'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BLOCK_WIDTH:    cfg_r.block_width    <= cfg_pwdata[8:0];
        REG_BLOCK_HEIGHT:   cfg_r.block_height   <= cfg_pwdata[8:0];
        REG_OVERLAP_WIDTH:  cfg_r.overlap_width  <= cfg_pwdata[7:0];
        REG_OVERLAP_HEIGHT: cfg_r.overlap_height <= cfg_pwdata[7:0];
        REG_BLOCKS_ACROSS:  cfg_r.blocks_across  <= cfg_pwdata[8:0];
        REG_BLOCKS_DOWN:    cfg_r.blocks_down    <= cfg_pwdata[8:0];
        REG_NORM_SCALE:     cfg_r.norm_scale     <= cfg_pwdata[23:0];
        REG_PLANE_BASE:     cfg_r.plane_base     <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_BLOCK_WIDTH:    cfg_prdata = {23'd0, cfg_r.block_width};
      REG_BLOCK_HEIGHT:   cfg_prdata = {23'd0, cfg_r.block_height};
      REG_OVERLAP_WIDTH:  cfg_prdata = {24'd0, cfg_r.overlap_width};
      REG_OVERLAP_HEIGHT: cfg_prdata = {24'd0, cfg_r.overlap_height};
      REG_BLOCKS_ACROSS:  cfg_prdata = {23'd0, cfg_r.blocks_across};
      REG_BLOCKS_DOWN:    cfg_prdata = {23'd0, cfg_r.blocks_down};
      REG_NORM_SCALE:     cfg_prdata = {8'd0, cfg_r.norm_scale};
      REG_PLANE_BASE:     cfg_prdata = {24'd0, cfg_r.plane_base};
      default:            cfg_prdata = '0;
    endcase
  end
endmodule

// ===== sv/oabs_ctrl.sv =====
// Controller: sequences capture, division, window read, the multiply stages and the output load.
`timescale 1ns / 1ps
module oabs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_ready,
  input  oabs_pkg::sts_t sts,
  output oabs_pkg::cmd_t cmd
);
  import oabs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_READ, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5, ST_DONE
  } state_t;

  localparam int DIV_STEPS = POSITION_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);

  state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_func == FUNC_LOAD) begin
          cmd.load = 1'b1;
        end else if (accept) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(DIV_STEPS - 1)) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_MUL4;
      ST_MUL4: state_nxt = ST_MUL5;
      ST_MUL5: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
endmodule

// ===== sv/oabs_dp.sv =====
// Datapath: position counters, overlap dividers, window tables, weighting and clamp.
`timescale 1ns / 1ps
module oabs_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  oabs_pkg::cfg_t cfg,
  input  oabs_pkg::cmd_t cmd,
  output oabs_pkg::sts_t sts,
  oabs_in_if.sink        in_ch,
  oabs_out_if.source     out_ch
);
  import oabs_pkg::*;

  localparam int PB  = POSITION_BITS;
  localparam int SB  = SAMPLE_BITS;
  localparam int P1B = SB + WIN_BITS + 1;   // sample times weight
  localparam int SUB = P1B + 1;             // sum of two
  localparam int P2B = SUB + WIN_BITS + 1;  // times second weight
  localparam int VB  = P2B + 1;
  localparam int LB  = SIZE_BITS + COUNT_BITS + 1;

  // Window tables
  logic [WIN_BITS-1:0] mem_xl [MAX_OVERLAP];
  logic [WIN_BITS-1:0] mem_xr [MAX_OVERLAP];
  logic [WIN_BITS-1:0] mem_yl [MAX_OVERLAP];
  logic [WIN_BITS-1:0] mem_yr [MAX_OVERLAP];
  logic [WIN_BITS-1:0] wxl_r, wxr_r, wyl_r, wyr_r;
  logic [WIN_BITS-1:0] load_val;

  assign load_val = (in_ch.table_value > ONE_Q15) ? ONE_Q15 : in_ch.table_value;

  // Position counters and end flags
  logic [PB-1:0]        col_r, row_r;
  logic                 le_r, fe_r;
  logic [SIZE_BITS-1:0] px, py;
  logic [LB-1:0]        width, height;
  logic                 le, fe;

  assign px = (cfg.block_width > SIZE_BITS'(cfg.overlap_width))
            ? cfg.block_width - SIZE_BITS'(cfg.overlap_width) : '0;
  assign py = (cfg.block_height > SIZE_BITS'(cfg.overlap_height))
            ? cfg.block_height - SIZE_BITS'(cfg.overlap_height) : '0;

  always_comb begin
    width  = LB'(cfg.blocks_across) * LB'(px) + LB'(cfg.overlap_width);
    height = LB'(cfg.blocks_down) * LB'(py) + LB'(cfg.overlap_height);
    if (width == '0) width = LB'(1);
    if (height == '0) height = LB'(1);
    le = ((LB'(col_r) + LB'(1)) >= width) || (col_r == {PB{1'b1}});
    fe = le && (((LB'(row_r) + LB'(1)) >= height) || (row_r == {PB{1'b1}}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.capture) begin
      if (le) begin
        col_r <= '0;
        row_r <= fe ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // Restoring dividers, one per axis: quotient is block number, remainder offset
  logic [PB-1:0]        qx_r, qy_r;
  logic [SIZE_BITS-1:0] rx_r, ry_r, dvx_r, dvy_r;
  logic                 vx_r, vy_r;
  logic [SIZE_BITS:0]   rx_sh, ry_sh;

  assign rx_sh = {rx_r, qx_r[PB-1]};
  assign ry_sh = {ry_r, qy_r[PB-1]};

  // Payload capture
  logic signed [SB-1:0] s_own_r, s_right_r, s_below_r, s_diag_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_own_r   <= in_ch.sample_own;
      s_right_r <= in_ch.sample_right;
      s_below_r <= in_ch.sample_below;
      s_diag_r  <= in_ch.sample_diag;
      le_r      <= le;
      fe_r      <= fe;
      dvx_r     <= px;
      dvy_r     <= py;
      vx_r      <= (px != '0) && (col_r >= PB'(px));
      vy_r      <= (py != '0) && (row_r >= PB'(py));
      qx_r      <= col_r - PB'(px);
      qy_r      <= row_r - PB'(py);
      rx_r      <= '0;
      ry_r      <= '0;
    end else if (cmd.div_step) begin
      if (rx_sh >= {1'b0, dvx_r}) begin
        rx_r <= SIZE_BITS'(rx_sh - {1'b0, dvx_r});
        qx_r <= {qx_r[PB-2:0], 1'b1};
      end else begin
        rx_r <= rx_sh[SIZE_BITS-1:0];
        qx_r <= {qx_r[PB-2:0], 1'b0};
      end
      if (ry_sh >= {1'b0, dvy_r}) begin
        ry_r <= SIZE_BITS'(ry_sh - {1'b0, dvy_r});
        qy_r <= {qy_r[PB-2:0], 1'b1};
      end else begin
        ry_r <= ry_sh[SIZE_BITS-1:0];
        qy_r <= {qy_r[PB-2:0], 1'b0};
      end
    end
  end

  // Overlap decision from the finished division
  logic                ovx, ovy, ovx_r, ovy_r;
  logic [IDX_BITS-1:0] idx_x, idx_y;

  assign ovx = vx_r && ((PB+1)'(qx_r) + (PB+1)'(1) < (PB+1)'(cfg.blocks_across))
             && (rx_r < SIZE_BITS'(cfg.overlap_width));
  assign ovy = vy_r && ((PB+1)'(qy_r) + (PB+1)'(1) < (PB+1)'(cfg.blocks_down))
             && (ry_r < SIZE_BITS'(cfg.overlap_height));
  assign idx_x = (rx_r >= SIZE_BITS'(MAX_OVERLAP)) ? IDX_BITS'(MAX_OVERLAP - 1)
                                                    : rx_r[IDX_BITS-1:0];
  assign idx_y = (ry_r >= SIZE_BITS'(MAX_OVERLAP)) ? IDX_BITS'(MAX_OVERLAP - 1)
                                                    : ry_r[IDX_BITS-1:0];

  // Table writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.load && in_ch.table_select == TBL_X_LEFT)  mem_xl[in_ch.table_index] <= load_val;
    if (cmd.load && in_ch.table_select == TBL_X_RIGHT) mem_xr[in_ch.table_index] <= load_val;
    if (cmd.load && in_ch.table_select == TBL_Y_LEFT)  mem_yl[in_ch.table_index] <= load_val;
    if (cmd.load && in_ch.table_select == TBL_Y_RIGHT) mem_yr[in_ch.table_index] <= load_val;
    wxl_r <= mem_xl[idx_x];
    wxr_r <= mem_xr[idx_x];
    wyl_r <= mem_yl[idx_y];
    wyr_r <= mem_yr[idx_y];
    ovx_r <= ovx;
    ovy_r <= ovy;
  end

  // Weighting stages; inputs stay held while the controller walks them
  logic signed [WIN_BITS:0]  wxl, wxr, wyl, wyr;
  logic signed [P1B-1:0]     p0_r, p1_r, p2_r, p3_r;
  logic signed [SUB-1:0]     top_r, bot_r;
  logic signed [P2B-1:0]     t1_r, t2_r;
  logic signed [VB-1:0]      v;
  logic [VB-1:0]             mag_r;
  logic                      neg_r, neg2_r;
  logic [VB-33:0]            mag_hi;
  logic [VB-33+NORM_BITS-1:0] a_r;
  logic [32+NORM_BITS-1:0]   b_r;

  assign wxl = ovx_r ? $signed({1'b0, wxl_r}) : '0;
  assign wxr = ovx_r ? $signed({1'b0, wxr_r}) : $signed({1'b0, ONE_Q15});
  assign wyl = ovy_r ? $signed({1'b0, wyl_r}) : '0;
  assign wyr = ovy_r ? $signed({1'b0, wyr_r}) : $signed({1'b0, ONE_Q15});
  assign v   = VB'(t1_r) + VB'(t2_r);
  assign mag_hi = mag_r[VB-1:32];

  always_ff @(posedge clk) begin
    p0_r   <= P1B'(s_own_r * wxr);
    p1_r   <= P1B'(s_right_r * wxl);
    p2_r   <= P1B'(s_below_r * wxr);
    p3_r   <= P1B'(s_diag_r * wxl);
    top_r  <= SUB'(p0_r) + SUB'(p1_r);
    bot_r  <= SUB'(p2_r) + SUB'(p3_r);
    t1_r   <= P2B'(top_r * wyr);
    t2_r   <= P2B'(bot_r * wyl);
    neg_r  <= v[VB-1];
    mag_r  <= v[VB-1] ? VB'(-v) : VB'(v);
    neg2_r <= neg_r;
    a_r    <= mag_hi * cfg.norm_scale;
    b_r    <= mag_r[31:0] * cfg.norm_scale;
  end

  // Rounding, base offset and clamp
  localparam int QB = VB - 32 + NORM_BITS + 1;
  logic [QB-1:0] qsum;
  logic [QB-1:0] q;
  logic [QB-1:0] base_w;
  logic [PIXEL_BITS-1:0] pix;

  always_comb begin
    qsum   = QB'(a_r) + QB'(b_r[32+NORM_BITS-1:32]) + (QB'(1) << 21);
    q      = qsum >> 22;
    base_w = QB'(cfg.plane_base);
    if (neg2_r) begin
      pix = (q > base_w) ? '0 : PIXEL_BITS'(base_w - q);
    end else begin
      pix = ((base_w + q) > QB'(PIXEL_MAX)) ? PIXEL_MAX : PIXEL_BITS'(base_w + q);
    end
  end

  // Output register
  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_pixel_r;
  logic                  out_le_r, out_fe_r;

  assign sts.out_full     = out_valid_r & ~out_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel     = out_pixel_r;
  assign out_ch.line_end  = out_le_r;
  assign out_ch.frame_end = out_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel_r <= pix;
      out_le_r    <= le_r;
      out_fe_r    <= fe_r;
    end
  end
endmodule

// ===== sv/overlap_add_block_synthesis.sv =====
// Top level: overlap-add synthesis of one 8-bit raster plane.
// A pixel item passes capture, 16 divider steps per axis on the column/row position,
// one window table read and the arithmetic steps. A finished result waits in the output
// register. Items are accepted only while idle, so the next pixel item waits for the
// previous one behind the 16-step dividers; a window load item is written when accepted.
// Reset: synchronous active-low rst_n clears counters, control and registers to defaults;
// window tables are not cleared and must be loaded before use.
`timescale 1ns / 1ps
module overlap_add_block_synthesis (
  input  logic                           clk,
  input  logic                           rst_n,
  oabs_in_if.sink                        in_ch,
  oabs_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [oabs_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [oabs_pkg::DATA_BITS-1:0] cfg_pwdata,
  output logic [oabs_pkg::DATA_BITS-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import oabs_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  oabs_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg(cfg)
  );

  oabs_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oabs_dp u_dp (
    .clk, .rst_n,
    .cfg    (cfg),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );
endmodule

// ===== bench/overlap_add_block_synthesis_tb.sv =====
// Testbench for overlap_add_block_synthesis: window loads and pixel streams checked against a predictor.
`timescale 1ns / 1ps
module overlap_add_block_synthesis_tb;
  import oabs_pkg::*;

  typedef struct {
    logic                          func;
    logic [1:0]                    sel;
    logic [6:0]                    idx;
    logic [15:0]                   val;
    logic signed [SAMPLE_BITS-1:0] own;
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [SAMPLE_BITS-1:0] below;
    logic signed [SAMPLE_BITS-1:0] diag;
  } px_item_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       line_end;
    logic       frame_end;
  } px_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [ADDR_BITS-1:0] cfg_paddr = '0;
  logic [DATA_BITS-1:0] cfg_pwdata = '0;
  logic [DATA_BITS-1:0] cfg_prdata;
  logic cfg_pready;

  oabs_in_if  in_ch();
  oabs_out_if out_ch();

  overlap_add_block_synthesis dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Shadow state of the block
  cfg_t        shadow_cfg;
  logic [15:0] col_pos, row_pos;
  logic [15:0] win_xl[MAX_OVERLAP], win_xr[MAX_OVERLAP];
  logic [15:0] win_yl[MAX_OVERLAP], win_yr[MAX_OVERLAP];

  px_item_t   pending_items[$];
  px_result_t expected_pixels[$];
  px_item_t   cur_item;
  bit         taken = 1'b0;
  bit         steady = 1'b0;
  int         mismatches = 0, pixels_checked = 0, loads_sent = 0, phases_run = 0;

  // Overlap zone test for one axis; returns window index through widx
  function automatic bit in_zone(int pos, int size, int ovl, int count, output int widx);
    int p, t, r;
    widx = 0;
    if (size <= ovl) return 1'b0;
    p = size - ovl;
    if (pos < p) return 1'b0;
    t = pos - p;
    r = t % p;
    if ((t / p) + 1 < count && r < ovl) begin
      widx = (r < MAX_OVERLAP) ? r : MAX_OVERLAP - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int axis_len(int size, int ovl, int count);
    int len;
    len = count * ((size > ovl) ? size - ovl : 0) + ovl;
    return (len == 0) ? 1 : len;
  endfunction

  // Apply one accepted item to the shadow state; pixel items yield a result
  function automatic bit synthesize_pixel(px_item_t it, output px_result_t res);
    int widx, width, height, sum;
    longint wxl, wxr, wyl, wyr, top, bot, v;
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [15:0]  wv;
    bit le, fe;
    res = '{default: '0};
    if (it.func == FUNC_LOAD) begin
      wv = (it.val > ONE_Q15) ? ONE_Q15 : it.val;
      case (it.sel)
        TBL_X_LEFT:  win_xl[it.idx] = wv;
        TBL_X_RIGHT: win_xr[it.idx] = wv;
        TBL_Y_LEFT:  win_yl[it.idx] = wv;
        default:     win_yr[it.idx] = wv;
      endcase
      return 1'b0;
    end
    wxl = 0; wxr = ONE_Q15; wyl = 0; wyr = ONE_Q15;
    if (in_zone(col_pos, shadow_cfg.block_width, shadow_cfg.overlap_width,
                shadow_cfg.blocks_across, widx)) begin
      wxl = win_xl[widx]; wxr = win_xr[widx];
    end
    if (in_zone(row_pos, shadow_cfg.block_height, shadow_cfg.overlap_height,
                shadow_cfg.blocks_down, widx)) begin
      wyl = win_yl[widx]; wyr = win_yr[widx];
    end
    top = longint'(it.own) * wxr + longint'(it.right) * wxl;
    bot = longint'(it.below) * wxr + longint'(it.diag) * wxl;
    v = top * wyr + bot * wyl;
    mag = (v < 0) ? -v : v;
    // Q.30 times Q0.24, back to integer with round half away from zero
    prod = {64'd0, mag} * {104'd0, shadow_cfg.norm_scale};
    prod = (prod + (128'd1 << 53)) >> 54;
    sum = int'(shadow_cfg.plane_base) + ((v < 0) ? -int'(prod) : int'(prod));
    if (sum < 0) sum = 0;
    if (sum > 255) sum = 255;
    width = axis_len(shadow_cfg.block_width, shadow_cfg.overlap_width, shadow_cfg.blocks_across);
    height = axis_len(shadow_cfg.block_height, shadow_cfg.overlap_height, shadow_cfg.blocks_down);
    le = (int'(col_pos) + 1 >= width) || (col_pos == 16'hFFFF);
    fe = le && ((int'(row_pos) + 1 >= height) || (row_pos == 16'hFFFF));
    if (le) begin
      col_pos = '0;
      row_pos = fe ? 16'd0 : row_pos + 16'd1;
    end else begin
      col_pos = col_pos + 16'd1;
    end
    res.pixel = sum[7:0];
    res.line_end = le;
    res.frame_end = fe;
    return 1'b1;
  endfunction

  // Input driver: next item presented at the falling edge
  always @(negedge clk) begin
    if (!in_ch.valid || taken) begin
      if (pending_items.size() > 0 && (steady || $urandom_range(0, 99) >= 25)) begin
        cur_item = pending_items.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.func         <= cur_item.func;
        in_ch.table_select <= cur_item.sel;
        in_ch.table_index  <= cur_item.idx;
        in_ch.table_value  <= cur_item.val;
        in_ch.sample_own   <= cur_item.own;
        in_ch.sample_right <= cur_item.right;
        in_ch.sample_below <= cur_item.below;
        in_ch.sample_diag  <= cur_item.diag;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    taken = 1'b0;
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    px_result_t exp_px, got;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      taken = 1'b1;
      if (synthesize_pixel(cur_item, exp_px)) expected_pixels.push_back(exp_px);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.pixel = out_ch.pixel;
      got.line_end = out_ch.line_end;
      got.frame_end = out_ch.frame_end;
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel transfer: %0d", got.pixel);
      end else begin
        exp_px = expected_pixels.pop_front();
        if (got !== exp_px) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: exp pix=%0d le=%0b fe=%0b got pix=%0d le=%0b fe=%0b",
                     exp_px.pixel, exp_px.line_end, exp_px.frame_end,
                     got.pixel, got.line_end, got.frame_end);
        end
      end
    end
  end

  // Register write over the config port; shadow updated at the write edge
  task automatic reg_write(logic [2:0] regno, logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {regno, 2'b00}; cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (regno)
      REG_BLOCK_WIDTH:    shadow_cfg.block_width    = data[SIZE_BITS-1:0];
      REG_BLOCK_HEIGHT:   shadow_cfg.block_height   = data[SIZE_BITS-1:0];
      REG_OVERLAP_WIDTH:  shadow_cfg.overlap_width  = data[OVL_BITS-1:0];
      REG_OVERLAP_HEIGHT: shadow_cfg.overlap_height = data[OVL_BITS-1:0];
      REG_BLOCKS_ACROSS:  shadow_cfg.blocks_across  = data[COUNT_BITS-1:0];
      REG_BLOCKS_DOWN:    shadow_cfg.blocks_down    = data[COUNT_BITS-1:0];
      REG_NORM_SCALE:     shadow_cfg.norm_scale     = data[NORM_BITS-1:0];
      default:            shadow_cfg.plane_base     = data[PIXEL_BITS-1:0];
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic set_geometry(int bw, int bh, int ow, int oh, int ba, int bd, int ns, int pb);
    reg_write(REG_BLOCK_WIDTH, bw);
    reg_write(REG_BLOCK_HEIGHT, bh);
    reg_write(REG_OVERLAP_WIDTH, ow);
    reg_write(REG_OVERLAP_HEIGHT, oh);
    reg_write(REG_BLOCKS_ACROSS, ba);
    reg_write(REG_BLOCKS_DOWN, bd);
    reg_write(REG_NORM_SCALE, ns);
    reg_write(REG_PLANE_BASE, pb);
    phases_run++;
  endtask

  // Drain: all items sent and all pixels back, then cover the pipeline depth
  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample(bit full);
    return full ? 24'($urandom) : 24'($urandom_range(0, 262143) - 131072);
  endfunction

  task automatic push_pixel(logic [23:0] o, logic [23:0] r, logic [23:0] b, logic [23:0] d);
    px_item_t it;
    it = '{func: FUNC_PIXEL, sel: 2'($urandom), idx: 7'($urandom), val: 16'($urandom),
           own: o, right: r, below: b, diag: d};
    pending_items.push_back(it);
  endtask

  task automatic push_load(logic [1:0] s, logic [6:0] i, logic [15:0] v);
    px_item_t it;
    it = '{func: FUNC_LOAD, sel: s, idx: i, val: v, own: 24'($urandom),
           right: 24'($urandom), below: 24'($urandom), diag: 24'($urandom)};
    pending_items.push_back(it);
    loads_sent++;
  endtask

  task automatic push_random(int n);
    bit full;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        push_load(2'($urandom), 7'($urandom),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)));
      end else begin
        full = ($urandom_range(0, 3) == 0);
        push_pixel(rand_sample(full), rand_sample(full), rand_sample(full), rand_sample(full));
      end
    end
  endtask

  initial begin
    int bw, bh;
    in_ch.valid = 1'b0; in_ch.func = FUNC_LOAD; in_ch.table_select = '0;
    in_ch.table_index = '0; in_ch.table_value = '0; in_ch.sample_own = '0;
    in_ch.sample_right = '0; in_ch.sample_below = '0; in_ch.sample_diag = '0;
    out_ch.ready = 1'b0;
    shadow_cfg = '{block_width: 32, block_height: 32, overlap_width: 16, overlap_height: 16,
                   blocks_across: 1, blocks_down: 1, norm_scale: 16384, plane_base: 0};
    col_pos = '0; row_pos = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every window entry; some values above 1.0 to hit saturation
    steady = 1'b1;
    for (int s = 0; s < 4; s++)
      for (int i = 0; i < MAX_OVERLAP; i++)
        push_load(2'(s), 7'(i), ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 32768)));
    push_load(TBL_X_RIGHT, 7'd127, 16'hFFFF);
    push_load(TBL_Y_LEFT, 7'd0, 16'h8001);
    // Reset geometry: extremes of the samples
    push_pixel(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    push_pixel(24'h800000, 24'h800000, 24'h800000, 24'h800000);
    push_pixel(24'h000000, 24'h000000, 24'h000000, 24'h000000);
    push_pixel(24'd1023, 24'd0, 24'd0, 24'd0);
    push_pixel(-24'sd1535, 24'd0, 24'd0, 24'd0);
    push_pixel(24'd512, 24'h555555, 24'hAAAAAA, 24'h123456);
    push_random(20);
    drain();
    steady = 1'b0;

    // Large geometry, full scale and base: clamping at both ends
    set_geometry(256, 256, 128, 128, 256, 256, 24'hFFFFFF, 255);
    push_pixel(24'h7FFFFF, 24'd0, 24'd0, 24'd0);
    push_pixel(24'h800000, 24'h800000, 24'h800000, 24'h800000);
    push_random(40);
    drain();
    // Small geometry, zero scale, zero base: two-pixel lines in two-line frames
    set_geometry(2, 2, 0, 0, 1, 1, 0, 0);
    push_random(30);
    drain();
    // Overlap equal to or above block size: axis treated as not overlapped
    set_geometry(4, 3, 4, 5, 3, 2, 16384, 128);
    push_random(40);
    drain();
    // Position left past the end: shrink the line mid-stream
    set_geometry(20, 20, 8, 8, 4, 4, 16384, 100);
    push_random(37);
    drain();
    set_geometry(3, 3, 1, 1, 1, 1, 65536, 64);
    push_random(10);
    drain();

    // Random geometries, mostly small, with random overlap sizes in both axes
    for (int ph = 0; ph < 10; ph++) begin
      steady = (ph == 4);
      bw = $urandom_range(2, 12);
      bh = $urandom_range(2, 12);
      set_geometry(bw, bh, $urandom_range(0, (ph % 3 == 0) ? bw : bw / 2),
                   $urandom_range(0, (ph % 3 == 0) ? bh : bh / 2),
                   $urandom_range(1, 4), $urandom_range(1, 4),
                   (ph == 7) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(4096, 65536),
                   $urandom_range(0, 255));
      push_random(80);
      drain();
    end
    steady = 1'b0;

    if (expected_pixels.size() != 0) mismatches++;
    $display("Covered %0d phases, %0d window loads and %0d pixel transfers checked.",
             phases_run, loads_sent, pixels_checked);
    $display("%0d mismatches found.", mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout waiting for pixel transfers.");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/oabs_pkg.sv
sv/oabs_if.sv
sv/oabs_cfg.sv
sv/oabs_ctrl.sv
sv/oabs_dp.sv
sv/overlap_add_block_synthesis.sv
bench/overlap_add_block_synthesis_tb.sv
